>>> design/ecie_pkg.sv
`default_nettype none

package ecie_pkg;

    // One input request: a byte of the Cues body and its end marker.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // One result request.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] cue_index;
        logic [63:0] cue_time;
        logic [63:0] cluster_position;
    } t_out_item;

    // Result status codes.
    localparam logic [1:0] ST_CUE_DONE  = 2'd0;
    localparam logic [1:0] ST_NOT_CUE   = 2'd1;
    localparam logic [1:0] ST_ID_LONG   = 2'd2;
    localparam logic [1:0] ST_SIZE_LONG = 2'd3;

    // EBML element IDs of interest.
    localparam logic [7:0] ID_CUE_POINT   = 8'hBB;
    localparam logic [7:0] ID_CUE_TIME    = 8'hB3;
    localparam logic [7:0] ID_TRACK_GROUP = 8'hB7;
    localparam logic [7:0] ID_CLUSTER_POS = 8'hF1;

    // Fixed widths of the header counters and of the value registers.
    localparam int ID_LEFT_W   = 3;
    localparam int SIZE_LEFT_W = 4;
    localparam int VAL_W       = 64;

    // Parser phases, one-hot.
    typedef enum logic [5:0] {
        PH_ID_FIRST   = 6'b000001,
        PH_ID_MORE    = 6'b000010,
        PH_SIZE_FIRST = 6'b000100,
        PH_SIZE_MORE  = 6'b001000,
        PH_LEAF       = 6'b010000,
        PH_SKIP       = 6'b100000
    } t_phase;

    // Length of a variable-length integer from the leading zeros of its
    // first byte: 1 to 8, or 9 when the byte is zero.
    function automatic logic [3:0] vint_len(input logic [7:0] b);
        logic [3:0] n;
        logic       found;
        n     = 4'd9;
        found = 1'b0;
        for (int k = 7; k >= 0; k--) begin
            if (!found && b[k]) begin
                n     = 4'(8 - k);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

>>> design/ecie_pipe_reg.sv
`default_nettype none

// Single register stage with valid and ready; takes a new request whenever
// it is empty or its content leaves in the same cycle.
module ecie_pipe_reg #(
    parameter type T = logic [7:0]
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_up_valid,
    output logic o_up_ready,
    input  T     i_up_data,
    output logic o_dn_valid,
    input  wire  i_dn_ready,
    output T     o_dn_data
);

    logic r_valid;
    logic n_valid;
    T     r_data;

    // Free when empty or when the held request is taken now.
    assign o_up_ready = !r_valid || i_dn_ready;

    always_comb begin
        n_valid = o_up_ready ? i_up_valid : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_up_valid && o_up_ready) begin
            r_data <= i_up_data;
        end
    end

    assign o_dn_valid = r_valid;
    assign o_dn_data  = r_data;

endmodule

`default_nettype wire

>>> design/ecie_parser.sv
`default_nettype none

// EBML header and Cues parser: all state updates for one byte happen in the
// cycle in which i_step is high.
module ecie_parser
    import ecie_pkg::*;
#(
    parameter int MAX_ID_BYTES   = 4,
    parameter int MAX_SIZE_BYTES = 8,
    parameter int INDEX_BITS     = 16
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_step,
    input  t_in_item  i_item,
    output logic      o_res_valid,
    output t_out_item o_res
);

    localparam int ID_W = 8 * MAX_ID_BYTES;

    t_phase                  r_phase, n_phase;
    logic [ID_W-1:0]         r_id, n_id;
    logic [ID_LEFT_W-1:0]    r_id_left, n_id_left;
    logic [VAL_W-1:0]        r_size, n_size;
    logic [SIZE_LEFT_W-1:0]  r_size_left, n_size_left;
    logic [VAL_W-1:0]        r_point, n_point;
    logic [VAL_W-1:0]        r_track, n_track;
    logic [VAL_W-1:0]        r_leaf, n_leaf;
    logic [VAL_W-1:0]        r_value, n_value;
    logic [VAL_W-1:0]        r_time, n_time;
    logic [VAL_W-1:0]        r_pos, n_pos;
    logic                    r_seen, n_seen;
    logic [INDEX_BITS-1:0]   r_count, n_count;
    logic                    r_stopped, n_stopped;

    logic [7:0]            b;
    logic [3:0]            len;
    logic                  d0, d1, d2;
    logic                  hdr_done;
    logic [VAL_W-1:0]      hdr_size;
    logic                  emit_cue;
    logic [INDEX_BITS-1:0] count_inc;
    logic [31:0]           count_wide;

    assign b          = i_item.data_byte;
    assign len        = vint_len(b);
    assign count_wide = 32'(r_count);

    // Nesting depth from the open parent counts.
    assign d0 = (r_point == '0);
    assign d1 = !d0 && (r_track == '0);
    assign d2 = !d0 && (r_track != '0);

    // Saturating cue counter.
    assign count_inc = (r_count != '1) ? r_count + 1'b1 : r_count;

    // Next state and result for one byte.
    always_comb begin
        n_phase     = r_phase;
        n_id        = r_id;
        n_id_left   = r_id_left;
        n_size      = r_size;
        n_size_left = r_size_left;
        n_point     = r_point;
        n_track     = r_track;
        n_leaf      = r_leaf;
        n_value     = r_value;
        n_time      = r_time;
        n_pos       = r_pos;
        n_seen      = r_seen;
        n_count     = r_count;
        n_stopped   = r_stopped;
        hdr_done    = 1'b0;
        hdr_size    = '0;
        emit_cue    = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_step && !r_stopped) begin
            // Every byte inside a cue point counts against its open parents.
            if (!d0) begin
                n_point = r_point - 1'b1;
            end
            if (d2) begin
                n_track = r_track - 1'b1;
            end

            unique case (r_phase)
                PH_ID_FIRST: begin
                    if (d0 && b != ID_CUE_POINT) begin
                        o_res_valid      = 1'b1;
                        o_res.status     = ST_NOT_CUE;
                        o_res.cue_index  = count_wide[15:0];
                        n_stopped        = 1'b1;
                    end else if (len > 4'(MAX_ID_BYTES)) begin
                        o_res_valid      = 1'b1;
                        o_res.status     = ST_ID_LONG;
                        o_res.cue_index  = count_wide[15:0];
                        n_stopped        = 1'b1;
                    end else begin
                        if (d0) begin
                            n_time = '0;
                            n_pos  = '0;
                            n_seen = 1'b0;
                        end
                        n_id      = ID_W'(b);
                        n_id_left = ID_LEFT_W'(len - 4'd1);
                        n_phase   = (len != 4'd1) ? PH_ID_MORE : PH_SIZE_FIRST;
                    end
                end
                PH_ID_MORE: begin
                    n_id      = ID_W'({r_id, b});
                    n_id_left = r_id_left - 1'b1;
                    if (r_id_left == ID_LEFT_W'(1)) begin
                        n_phase = PH_SIZE_FIRST;
                    end
                end
                PH_SIZE_FIRST: begin
                    if (len > 4'(MAX_SIZE_BYTES)) begin
                        o_res_valid      = 1'b1;
                        o_res.status     = ST_SIZE_LONG;
                        o_res.cue_index  = count_wide[15:0];
                        n_stopped        = 1'b1;
                    end else begin
                        // Marker bit and leading zeros are cleared.
                        n_size      = VAL_W'(b & (8'hFF >> len));
                        n_size_left = SIZE_LEFT_W'(len - 4'd1);
                        if (len == 4'd1) begin
                            hdr_done = 1'b1;
                            hdr_size = n_size;
                        end else begin
                            n_phase = PH_SIZE_MORE;
                        end
                    end
                end
                PH_SIZE_MORE: begin
                    n_size      = {r_size[VAL_W-9:0], b};
                    n_size_left = r_size_left - 1'b1;
                    if (r_size_left == SIZE_LEFT_W'(1)) begin
                        hdr_done = 1'b1;
                        hdr_size = n_size;
                    end
                end
                PH_LEAF: begin
                    n_value = {r_value[VAL_W-9:0], b};
                    n_leaf  = r_leaf - 1'b1;
                    if (r_leaf == VAL_W'(1)) begin
                        if (r_id == ID_W'(ID_CUE_TIME)) begin
                            n_time = n_value;
                        end else if (r_id == ID_W'(ID_CLUSTER_POS)) begin
                            n_pos = n_value;
                        end
                        n_phase = PH_ID_FIRST;
                    end
                end
                PH_SKIP: begin
                    n_leaf = r_leaf - 1'b1;
                    if (r_leaf == VAL_W'(1)) begin
                        n_phase = PH_ID_FIRST;
                    end
                end
                default: begin
                    n_phase = PH_ID_FIRST;
                end
            endcase

            // Element header complete: open it, start a leaf or skip it.
            if (hdr_done) begin
                n_phase = PH_ID_FIRST;
                if (d0) begin
                    n_point = hdr_size;
                    n_track = '0;
                    if (hdr_size == '0) begin
                        emit_cue = 1'b1;
                    end
                end else if (d1 && r_id == ID_W'(ID_CUE_TIME)) begin
                    n_value = '0;
                    n_leaf  = hdr_size;
                    if (hdr_size == '0) begin
                        n_time = '0;
                    end else begin
                        n_phase = PH_LEAF;
                    end
                end else if (d1 && r_id == ID_W'(ID_TRACK_GROUP) && !r_seen) begin
                    n_seen  = 1'b1;
                    n_track = hdr_size;
                end else if (d2 && r_id == ID_W'(ID_CLUSTER_POS)) begin
                    n_value = '0;
                    n_leaf  = hdr_size;
                    if (hdr_size == '0) begin
                        n_pos = '0;
                    end else begin
                        n_phase = PH_LEAF;
                    end
                end else begin
                    n_leaf  = hdr_size;
                    n_phase = (hdr_size != '0) ? PH_SKIP : PH_ID_FIRST;
                end
            end

            // Parent ends: the cue point closes, or the track group closes.
            if (!n_stopped && !d0) begin
                if (r_point == VAL_W'(1)) begin
                    emit_cue = 1'b1;
                    n_track  = '0;
                    n_phase  = PH_ID_FIRST;
                end else if (d2 && r_track == VAL_W'(1)) begin
                    n_phase = PH_ID_FIRST;
                end
            end

            if (emit_cue) begin
                o_res_valid            = 1'b1;
                o_res.status           = ST_CUE_DONE;
                o_res.cue_index        = count_wide[15:0];
                o_res.cue_time         = n_time;
                o_res.cluster_position = n_pos;
                n_count                = count_inc;
            end
        end

        // The final byte returns the parser to its reset state.
        if (i_step && i_item.last_byte) begin
            n_phase     = PH_ID_FIRST;
            n_id        = '0;
            n_id_left   = '0;
            n_size      = '0;
            n_size_left = '0;
            n_point     = '0;
            n_track     = '0;
            n_leaf      = '0;
            n_value     = '0;
            n_time      = '0;
            n_pos       = '0;
            n_seen      = 1'b0;
            n_count     = '0;
            n_stopped   = 1'b0;
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ID_FIRST;
            r_id        <= '0;
            r_id_left   <= '0;
            r_size      <= '0;
            r_size_left <= '0;
            r_point     <= '0;
            r_track     <= '0;
            r_leaf      <= '0;
            r_value     <= '0;
            r_time      <= '0;
            r_pos       <= '0;
            r_seen      <= 1'b0;
            r_count     <= '0;
            r_stopped   <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_id        <= n_id;
            r_id_left   <= n_id_left;
            r_size      <= n_size;
            r_size_left <= n_size_left;
            r_point     <= n_point;
            r_track     <= n_track;
            r_leaf      <= n_leaf;
            r_value     <= n_value;
            r_time      <= n_time;
            r_pos       <= n_pos;
            r_seen      <= n_seen;
            r_count     <= n_count;
            r_stopped   <= n_stopped;
        end
    end

endmodule

`default_nettype wire

>>> design/ebml_cue_index_extractor.sv
// Path: an accepted byte waits in the input register, then the parse logic writes
// any result it causes into the result register.
// Throughput: one byte per cycle, unless a held result is stalled by i_out_ready.
// Reset: synchronous, active low; clears both stage valid bits and all parse state.
// A byte marked last_byte returns the parser to its reset state after it is parsed.
`default_nettype none

module ebml_cue_index_extractor
    import ecie_pkg::*;
#(
    parameter int MAX_ID_BYTES   = 4,
    parameter int MAX_SIZE_BYTES = 8,
    parameter int INDEX_BITS     = 16
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  wire       i_out_ready,
    output t_out_item o_out_data
);

    logic      in_valid;
    t_in_item  in_item;
    logic      res_free;
    logic      step;
    logic      res_valid;
    t_out_item res;

    // Input register.
    ecie_pipe_reg #(
        .T (t_in_item)
    ) u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (i_in_valid),
        .o_up_ready (o_in_ready),
        .i_up_data  (i_in_data),
        .o_dn_valid (in_valid),
        .i_dn_ready (res_free),
        .o_dn_data  (in_item)
    );

    // A byte is parsed when the result register can take what it may produce.
    assign step = in_valid && res_free;

    ecie_parser #(
        .MAX_ID_BYTES   (MAX_ID_BYTES),
        .MAX_SIZE_BYTES (MAX_SIZE_BYTES),
        .INDEX_BITS     (INDEX_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register.
    ecie_pipe_reg #(
        .T (t_out_item)
    ) u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (res_valid),
        .o_up_ready (res_free),
        .i_up_data  (res),
        .o_dn_valid (o_out_valid),
        .i_dn_ready (i_out_ready),
        .o_dn_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> design/ecie_checker.sv
`default_nettype none

module ecie_checker
    import ecie_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       o_in_ready,
    input t_in_item  i_in_data,
    input wire       o_out_valid,
    input wire       i_out_ready,
    input t_out_item o_out_data
);

    // A stalled input request holds its payload.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input request changed while stalled");

    // A stalled result request holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result request changed while stalled");

    // Error results carry no time or position.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_CUE_DONE |->
            o_out_data.cue_time == '0 && o_out_data.cluster_position == '0)
        else $error("error result with nonzero payload");

    // Nothing is offered just after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

    // With the result register empty, input is always taken.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind ebml_cue_index_extractor ecie_checker u_ecie_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
